FILE: rtl/core/bf3_pkg.sv
// Shared types and constants of the 3x3 box filter.
package bf3_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration registers.
  localparam int CFG_W     = 10;
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(512);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  // Row and column counters hold up to two rows past the last frame row.
  localparam int CNT_W = CFG_W + 1;

  // Queue between the front end and the filter datapath.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Per-item control decided by the front end.
  typedef struct packed {
    logic has_result;
    logic interior;
    logic last;
  } bf3_ctrl_t;

endpackage

FILE: rtl/core/bf3_if.sv
// Stream and configuration channel interfaces of the 3x3 box filter.
interface bf3_in_if #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

interface bf3_out_if #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] value;
  logic                  end_of_frame;

  modport source (output valid, value, end_of_frame, input ready);
  modport sink   (input valid, value, end_of_frame, output ready);
endinterface

interface bf3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bf3_pkg::CFG_IDX_W-1:0] index;
  logic [bf3_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bf3_front.sv
// Front end: frame counters, item classification and the two line stores.
module bf3_front #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bf3_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                           cfg_ready_o,
  input  logic                           in_valid_i,
  input  logic                           in_kind_i,
  input  logic [PIXEL_BITS-1:0]          in_pixel_i,
  output logic                           in_ready_o,
  input  logic [bf3_pkg::QCNT_W-1:0]     q_count_i,
  output logic                           push_o,
  output bf3_pkg::bf3_ctrl_t             push_ctrl_o,
  output logic [3*PIXEL_BITS-1:0]        push_col_o,
  output logic                           clear_o
);
  import bf3_pkg::*;

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [CNT_W-1:0] W_CAP = CNT_W'((MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
  localparam logic [CNT_W:0]   TWO_X = (CNT_W + 1)'(2);

  logic [CFG_W-1:0] width_q, height_q;
  logic [CNT_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
  logic [CNT_W-1:0] in_row_d, in_col_d, out_row_d, out_col_d;
  logic [CNT_W-1:0] w_eff, h_eff;
  logic             cfg_hit, accept, draining, drop, go;
  logic [PIXEL_BITS-1:0] pix_v;
  logic [ADDR_W-1:0]     rd_addr;
  bf3_ctrl_t             ctrl;

  // Line stores: each entry holds {upper, middle} of one column.
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_data_q, byp_data_q, col_old, wr_data;
  logic                    byp_q;

  // Second front stage: read data arrives, store is updated, item is pushed.
  logic                  f1_v_q;
  logic [ADDR_W-1:0]     f1_addr_q;
  logic [PIXEL_BITS-1:0] f1_pix_q;
  bf3_ctrl_t             f1_ctrl_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);
  assign clear_o = cfg_hit;

  always_comb begin
    if (width_q == '0) begin
      w_eff = ONE;
    end else if (CNT_W'(width_q) > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = CNT_W'(width_q);
    end
    h_eff = (height_q == '0) ? ONE : CNT_W'(height_q);
  end

  // An item in flight in stage one has a queue slot reserved for it.
  assign in_ready_o = ((QCNT_W + 1)'(q_count_i) + (QCNT_W + 1)'(f1_v_q)) <
                      (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid_i && in_ready_o;
  assign draining = in_row_q >= h_eff;
  assign drop     = in_kind_i && !draining;
  assign go       = accept && !drop;
  assign pix_v    = draining ? '0 : in_pixel_i;
  assign rd_addr  = ADDR_W'(in_col_q);

  always_comb begin
    ctrl.has_result = !(in_row_q == '0 || (in_row_q == ONE && in_col_q == '0));
    ctrl.interior   = out_row_q >= ONE && ({1'b0, out_row_q} + TWO_X) <= {1'b0, h_eff} &&
                      out_col_q >= ONE && ({1'b0, out_col_q} + TWO_X) <= {1'b0, w_eff};
    ctrl.last       = (out_row_q + ONE) >= h_eff && (out_col_q + ONE) >= w_eff;
  end

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (cfg_hit) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (go) begin
      if (ctrl.has_result && ctrl.last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else begin
        if ((in_col_q + ONE) >= w_eff) begin
          in_col_d = '0;
          in_row_d = in_row_q + ONE;
        end else begin
          in_col_d = in_col_q + ONE;
        end
        if (ctrl.has_result) begin
          if ((out_col_q + ONE) >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_q + ONE;
          end else begin
            out_col_d = out_col_q + ONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= FRAME_WIDTH_RST;
      height_q  <= FRAME_HEIGHT_RST;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      f1_v_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      f1_v_q    <= go;
    end
  end

  // The entry read now may be the one stage one writes in this same cycle
  // (frame width one); that write is forwarded instead of the stale read.
  assign col_old = byp_q ? byp_data_q : rd_data_q;
  assign wr_data = {col_old[PIXEL_BITS-1:0], f1_pix_q};

  always_ff @(posedge clk_i) begin
    if (go) begin
      rd_data_q  <= line_mem[rd_addr];
      byp_q      <= f1_v_q && (f1_addr_q == rd_addr);
      byp_data_q <= wr_data;
      f1_addr_q  <= rd_addr;
      f1_pix_q   <= pix_v;
      f1_ctrl_q  <= ctrl;
    end
    if (f1_v_q) begin
      line_mem[f1_addr_q] <= wr_data;
    end
  end

  assign push_o      = f1_v_q;
  assign push_ctrl_o = f1_ctrl_q;
  assign push_col_o  = {col_old, f1_pix_q};

endmodule

FILE: rtl/core/bf3_queue.sv
// Small FIFO that decouples the front end from the filter datapath.
module bf3_queue #(
  parameter int DATA_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          push_data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [DATA_W-1:0]          data_o,
  output logic [bf3_pkg::QCNT_W-1:0] count_o
);
  import bf3_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/bf3_back.sv
// Filter datapath: 3x3 window, neighborhood sum, divide by nine, output register.
module bf3_back #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    q_valid_i,
  input  bf3_pkg::bf3_ctrl_t      q_ctrl_i,
  input  logic [3*PIXEL_BITS-1:0] q_col_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PIXEL_BITS-1:0]   out_value_o,
  output logic                    out_eof_o
);
  import bf3_pkg::*;

  // Exact floor(x / 9) for x below 2**SUM_W as (x * DIV_M) >> DIV_K.
  localparam int SUM_W  = PIXEL_BITS + 4;
  localparam int DIV_K  = SUM_W + 4;
  localparam int MUL_W  = DIV_K - 3;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_M = MUL_W'(((1 << DIV_K) + 8) / 9);

  logic [PIXEL_BITS-1:0] win_q [3][3];
  logic [SUM_W-1:0]      sum;
  logic                  en;

  logic                  v1_q, v2_q, v3_q, out_valid_q;
  bf3_ctrl_t             c1_q, c2_q, c3_q;
  logic [SUM_W-1:0]      sum_q;
  logic [PIXEL_BITS-1:0] cen2_q, cen3_q, value_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  eof_q;

  // The whole datapath advances together whenever the output register frees.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_valid_i;

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum = sum + SUM_W'(win_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_q[r][c] <= '0;
          end
        end
      end else if (pop_o) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
          win_q[r][2] <= q_col_i[(2-r)*PIXEL_BITS +: PIXEL_BITS];
        end
      end
      if (en) begin
        v1_q        <= pop_o && q_ctrl_i.has_result;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= q_ctrl_i;
      sum_q   <= sum;
      cen2_q  <= win_q[1][1];
      c2_q    <= c1_q;
      prod_q  <= PROD_W'(sum_q) * PROD_W'(DIV_M);
      cen3_q  <= cen2_q;
      c3_q    <= c2_q;
      value_q <= c3_q.interior ? PIXEL_BITS'(prod_q >> DIV_K) : cen3_q;
      eof_q   <= c3_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = value_q;
  assign out_eof_o   = eof_q;

endmodule

FILE: rtl/core/box_filter_3x3_top.sv
// Top level of the streaming 3x3 box filter.
// This block takes a frame of grey pixels in raster order and returns it in
// raster order: a pixel in the first or last row or column passes through
// unchanged, every other pixel becomes the sum of its 3x3 neighborhood divided
// by nine and truncated. Each input transfer is either a pixel (kind 0) or a
// flush tick (kind 1); the result for raster position k leaves after input
// transfer k+W+1 (W is the frame width), so after the W*H pixels of a frame
// the source sends W+1 more transfers to drain the rest. A flush sent before
// the last pixel of a frame is taken and ignored; a pixel sent while the frame
// drains counts as a flush. The result that carries end_of_frame closes the
// frame and the next transfer starts a new one. While the output is not
// stalled, the block sustains one input transfer per clock: the front end
// reads and rewrites one line-store entry per pixel through a single read
// port and a single write port, and the filter datapath moves the window and
// output forward once per clock. The result an input transfer releases
// passes through the front end's second stage, the queue, and the window,
// sum and product registers of the datapath before the output register.
// A four-entry queue between front end and datapath lets each
// side stall on its own, and the output register holds a result until it is
// taken while new pixels keep coming in. Writing frame_width (index 0) or
// frame_height (index 1) restarts the frame; do this only while the block is
// idle. The configuration channel never stalls, and writes to other indexes
// are ignored. Width 0 counts as 1 and widths above MAX_WIDTH are capped;
// height 0 counts as 1. The line stores need no clearing pass after reset.
module box_filter_3x3_top #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bf3_cfg_if.sink     cfg_i,
  bf3_in_if.sink      in_i,
  bf3_out_if.source   out_o
);
  import bf3_pkg::*;

  // One queue entry: control flags plus the new window column.
  localparam int Q_DATA_W = $bits(bf3_ctrl_t) + 3 * PIXEL_BITS;

  logic                    push, pop, q_valid, clear;
  bf3_ctrl_t               push_ctrl, q_ctrl;
  logic [3*PIXEL_BITS-1:0] push_col, q_col;
  logic [Q_DATA_W-1:0]     q_data;
  logic [QCNT_W-1:0]       q_count;

  bf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_pixel_i  (in_i.pixel),
    .in_ready_o  (in_i.ready),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_ctrl_o (push_ctrl),
    .push_col_o  (push_col),
    .clear_o     (clear)
  );

  bf3_queue #(
    .DATA_W (Q_DATA_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctrl, push_col}),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign q_ctrl = bf3_ctrl_t'(q_data[Q_DATA_W-1 -: $bits(bf3_ctrl_t)]);
  assign q_col  = q_data[3*PIXEL_BITS-1:0];

  bf3_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .q_valid_i   (q_valid),
    .q_ctrl_i    (q_ctrl),
    .q_col_i     (q_col),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.value),
    .out_eof_o   (out_o.end_of_frame)
  );

endmodule

FILE: rtl/core/bf3_checker.sv
// Port-level checks of the 3x3 box filter and their binding to the top level.
module bf3_checker #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [PIXEL_BITS-1:0] out_value_i,
  input logic                  out_eof_i
);

  // A result is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_eof_i))
    else $error("result payload changed while stalled");

  // The configuration channel never applies backpressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration channel stalled");

  // No result can be pending right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result present right after reset");

endmodule

bind box_filter_3x3_top bf3_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_bf3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_eof_i   (out_o.end_of_frame)
);

FILE: dv/tb_top.sv
// Self-checking testbench of the streaming 3x3 box filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int PB    = PIXEL_BITS_DEF;

  // A 3x3 neighborhood holds nine pixels; the interior mean divides by this.
  localparam int unsigned NEIGHBORS = 9;

  // Item kinds on the input stream.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_IDLE      = 14;
  localparam int SETTLE_CYCLES = 20;
  // The receiver stops taking results for this long once in a while.
  localparam int LONG_HOLD     = 300;
  localparam int LIMIT_CYCLES  = 1_000_000;

  typedef struct {
    logic          kind;
    logic [PB-1:0] pixel;
    bit            wait_drain;  // sender pauses until every result is in
  } stim_t;

  typedef struct {
    logic [PB-1:0] value;
    logic          eof;
  } blur_out_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bf3_cfg_if               cfg_if ();
  bf3_in_if  #(.PIXEL_BITS(PB)) in_if  ();
  bf3_out_if #(.PIXEL_BITS(PB)) out_if ();

  box_filter_3x3_top #(
    .MAX_WIDTH (MAX_W),
    .PIXEL_BITS(PB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Items waiting to be driven, and the filtered pixels still owed by the block.
  stim_t     stream_q[$];
  blur_out_t blurred_q[$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;

  // Shadow copy of the filter: line stores, window, raster counters, registers.
  logic [PB-1:0]    line_above [MAX_W];
  logic [PB-1:0]    line_mid   [MAX_W];
  logic [PB-1:0]    win [3][3] = '{default: '0};
  int unsigned      row_in  = 0;
  int unsigned      col_in  = 0;
  int unsigned      row_out = 0;
  int unsigned      col_out = 0;
  logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

  function automatic int unsigned eff_width(logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height(logic [CFG_W-1:0] h);
    return (h == 0) ? 1 : h;
  endfunction

  // Advance the shadow filter by one accepted item. Returns 1 when the item
  // releases a pixel, which is then given in res.
  function automatic bit blur_step(logic kind, logic [PB-1:0] px, output blur_out_t res);
    int unsigned   w;
    int unsigned   h;
    int unsigned   col;
    int unsigned   n;
    int unsigned   sum;
    logic [PB-1:0] v;
    bit            draining;
    bit            inner;
    bit            last;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    res = '{default: '0};
    draining = (row_in >= h);
    // A flush that comes before the last pixel of the frame changes nothing.
    if (kind == KIND_FLUSH && !draining) return 1'b0;
    // While the frame drains, a pixel counts as a flush and its value is dropped.
    v = draining ? '0 : px;
    col = (col_in >= MAX_W) ? MAX_W - 1 : col_in;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_above[col];
    win[1][2] = line_mid[col];
    win[2][2] = v;
    line_above[col] = line_mid[col];
    line_mid[col]   = v;
    n = row_in * w + col_in;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    // The first row and one pixel fill the window before anything leaves.
    if (n < w + 1) return 1'b0;
    inner = row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
    if (inner) begin
      sum = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sum += win[r][c];
        end
      end
      res.value = PB'(sum / NEIGHBORS);
    end else begin
      res.value = win[1][1];
    end
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    res.eof = last;
    if (last) begin
      row_in  = 0;
      col_in  = 0;
      row_out = 0;
      col_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // Scoreboard: every transfer on the three channels is seen here, at the
  // clock edge that completes it. Register writes update the shadow filter,
  // input transfers produce the pixels owed, output transfers are checked
  // against the oldest one owed.
  always @(posedge clk_i) begin
    blur_out_t want;
    blur_out_t owed;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_FRAME_WIDTH) width_reg = cfg_if.data;
        if (cfg_if.index == CFG_FRAME_HEIGHT) height_reg = cfg_if.data;
        // A write to either register starts the frame over; the line stores
        // keep what they hold.
        if (cfg_if.index == CFG_FRAME_WIDTH || cfg_if.index == CFG_FRAME_HEIGHT) begin
          win     = '{default: '0};
          row_in  = 0;
          col_in  = 0;
          row_out = 0;
          col_out = 0;
        end
      end
      if (in_if.valid && in_if.ready) begin
        n_accepted++;
        if (blur_step(in_if.kind, in_if.pixel, owed)) blurred_q.push_back(owed);
      end
      if (out_if.valid && out_if.ready) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected output transfer, value %0d end_of_frame %0b",
                   $time, out_if.value, out_if.end_of_frame);
          n_errors++;
        end else begin
          want = blurred_q.pop_front();
          if (out_if.value !== want.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want.value, out_if.value);
            n_errors++;
          end
          if (out_if.end_of_frame !== want.eof) begin
            $display("%0t: end_of_frame mismatch, expected %0b, got %0b",
                     $time, want.eof, out_if.end_of_frame);
            n_errors++;
          end
        end
      end
    end
  end

  // Input driver. After each transfer it draws an idle gap; now and then it
  // switches into a stretch without gaps. An item marked wait_drain is held
  // back until the block owes nothing any more. The check skips the edge of
  // a transfer, so the expectation of that transfer is already on the queue.
  int unsigned tx_gap   = 0;
  bit          tx_burst = 1'b0;

  always @(posedge clk_i) begin
    stim_t head;
    bit    took;
    took = in_if.valid && in_if.ready;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || took) begin
      if (took) begin
        if ($urandom_range(0, 40) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (tx_gap != 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (stream_q.size() != 0 &&
                   !(stream_q[0].wait_drain && (took || blurred_q.size() != 0))) begin
        head = stream_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind  <= head.kind;
        in_if.pixel <= head.pixel;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output receiver. It draws a stall before each result and, once early in
  // the run and then every 1500 results, holds ready low for a long stretch
  // so the internal queue fills and the input side backs up.
  int unsigned rx_count = 0;
  int unsigned rx_gap   = 0;
  int unsigned rx_hold  = 0;
  bit          rx_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        rx_count++;
        if (rx_count % 1500 == 100) rx_hold = LONG_HOLD;
        if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void push_item(logic kind, logic [PB-1:0] px, bit wait_drain);
    stim_t it;
    it.kind       = kind;
    it.pixel      = px;
    it.wait_drain = wait_drain;
    stream_q.push_back(it);
    n_queued++;
  endfunction

  // Mostly uniform grey values, with the two extremes made more likely.
  function automatic logic [PB-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PB'($urandom);
    endcase
  endfunction

  // Writes both frame registers back to back, sometimes with a write to an
  // undecoded index in between. Valid stays high across the writes.
  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_FRAME_WIDTH;
    cfg_if.data  <= w;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if ($urandom_range(0, 2) == 0) begin
      cfg_if.index <= $urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
      cfg_if.data  <= CFG_W'($urandom);
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.index <= CFG_FRAME_HEIGHT;
    cfg_if.data  <= h;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Queues one frame for the given register values: the pixels in raster
  // order with a stray early flush now and then, followed by width+1 drain
  // items of mixed kind. A broken frame is a random run of items of any kind.
  task automatic queue_frame(int unsigned w, int unsigned h, bit broken);
    int unsigned ew;
    int unsigned npix;
    ew   = eff_width(CFG_W'(w));
    npix = ew * eff_height(CFG_W'(h));
    if (broken) begin
      npix = $urandom_range(0, npix + ew);
      for (int unsigned i = 0; i < npix; i++) begin
        push_item(1'($urandom), rand_pixel(), 1'b0);
      end
    end else begin
      for (int unsigned i = 0; i < npix; i++) begin
        if ($urandom_range(0, 15) == 0) push_item(KIND_FLUSH, rand_pixel(), 1'b0);
        push_item(KIND_PIXEL, rand_pixel(), $urandom_range(0, 60) == 0);
      end
      for (int unsigned i = 0; i <= ew; i++) begin
        push_item(1'($urandom), rand_pixel(), i == 0 && $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Phases end only when every queued item has been taken, every owed pixel
  // has come out and the pipeline has had time to empty, since items that
  // release nothing may still be inside.
  task automatic wait_idle();
    while (n_accepted != n_queued || blurred_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned w;
    int unsigned h;
    int unsigned nframes;
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i] = '0;
      line_mid[i]   = '0;
    end
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FRAME_WIDTH;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_PIXEL;
    in_if.pixel  = '0;
    out_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed 3x3 frame: one interior pixel whose mean truncates, the two
    // grey extremes, a flush before the first pixel and one in mid-frame, and
    // a drain that mixes flushes with pixels that must be ignored. The first
    // drain item waits until every owed pixel has come out.
    set_frame(10'd3, 10'd3);
    push_item(KIND_FLUSH, 8'd17, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd0, 1'b0);
    push_item(KIND_FLUSH, 8'd99, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd254, 1'b0);
    push_item(KIND_FLUSH, 8'd0, 1'b1);
    push_item(KIND_PIXEL, 8'd7, 1'b0);
    push_item(KIND_FLUSH, 8'd255, 1'b0);
    push_item(KIND_PIXEL, 8'd200, 1'b0);
    wait_idle();

    // Zero width and zero height both count as one: a single-pixel frame.
    set_frame(10'd0, 10'd0);
    push_item(KIND_PIXEL, 8'd128, 1'b0);
    push_item(KIND_PIXEL, 8'd1, 1'b0);
    push_item(KIND_FLUSH, 8'd0, 1'b0);
    wait_idle();

    // Random small frames, one or two per setting, with the odd broken one.
    n_rand = 0;
    while (n_rand < 630) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(9, 24);
      set_frame(CFG_W'(w), CFG_W'(h));
      nframes = $urandom_range(1, 2);
      for (int unsigned f = 0; f < nframes; f++) begin
        queue_frame(w, h, $urandom_range(0, 7) == 0);
      end
      n_rand += nframes * (eff_width(CFG_W'(w)) * (eff_height(CFG_W'(h)) + 1) + 1);
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("== FAIL ==");
    $finish;
  end

endmodule
